/* rtl/vsq_pkg.sv */
// Shared types and constants for the velocity swept quadrilateral block.
// Holds the transaction payload structs, the CORDIC word formats and the
// output saturation helper. No dependencies.
`timescale 1ns / 1ps

package vsq_pkg;

   // Velocity enters the CORDIC with GUARD_BITS extra fraction bits
   localparam int GUARD_BITS = 16;
   // Gain product u = r * INV_GAIN_Q30 is rounded back by ROUND_BITS
   localparam int ROUND_BITS = 30;
   // x/y hold the velocity, up to 2^39 after the guard shift, times CORDIC gain
   localparam int XW = 44;
   // u/w hold r * 1/K in Q30, below 2^54, times CORDIC gain
   localparam int UW = 58;
   // Offset and sweep components, the size of the radius or of the velocity
   localparam int OW = 27;
   // Corner sums before saturation
   localparam int SW = 35;
   localparam int NUM_CORNER_COORDS = 8;

   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [23:0] speed_x;
      logic signed [23:0] speed_y;
      logic [23:0]        circle_radius;
   } req_type;

   typedef struct packed {
      logic signed [31:0] c1_x;
      logic signed [31:0] c1_y;
      logic signed [31:0] c2_x;
      logic signed [31:0] c2_y;
      logic signed [31:0] c3_x;
      logic signed [31:0] c3_y;
      logic signed [31:0] c4_x;
      logic signed [31:0] c4_y;
      logic               clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [UW-1:0] u;
      logic signed [UW-1:0] w;
   } cord_type;

   // Data that rides alongside the rotation stages untouched
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic [23:0]        r;
      logic               flip;
      logic               still;
      logic               stretch;
   } side_type;

   typedef logic signed [SW-1:0] sum_type;

   // Returns {clip, value}: value clamped to the signed 32-bit range
   function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
      logic [32:0] res;
      if (v[SW-1:31] == '0 || v[SW-1:31] == '1) begin
         res = {1'b0, v[31:0]};
      end else if (v[SW-1]) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b1, 32'h7FFF_FFFF};
      end
      return res;
   endfunction

endpackage

/* rtl/vsq_rotate_stage.sv */
// One vectoring CORDIC micro-rotation with its pipeline register.
// Drives (x, y) toward the x axis and turns (u, w) the opposite way.
// Depends on vsq_pkg.
`timescale 1ns / 1ps

module vsq_rotate_stage #(
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  vsq_pkg::cord_type in_cord,
   input  vsq_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_stall,
   output vsq_pkg::cord_type out_cord,
   output vsq_pkg::side_type out_side
);
   import vsq_pkg::*;

   logic     valid_ff;
   logic     take;
   cord_type cord_ff;
   cord_type cord_in;
   side_type side_ff;

   always_comb begin
      if (!in_cord.y[XW-1]) begin
         cord_in.x = in_cord.x + (in_cord.y >>> SHIFT);
         cord_in.y = in_cord.y - (in_cord.x >>> SHIFT);
         cord_in.u = in_cord.u - (in_cord.w >>> SHIFT);
         cord_in.w = in_cord.w + (in_cord.u >>> SHIFT);
      end else begin
         cord_in.x = in_cord.x - (in_cord.y >>> SHIFT);
         cord_in.y = in_cord.y + (in_cord.x >>> SHIFT);
         cord_in.u = in_cord.u + (in_cord.w >>> SHIFT);
         cord_in.w = in_cord.w - (in_cord.u >>> SHIFT);
      end
   end

   // A bubble in this stage can always be filled
   assign take     = !valid_ff || !out_stall;
   assign in_stall = !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         cord_ff <= cord_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_cord  = cord_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/velocity_swept_quad_top.sv */
// Top level of the velocity swept quadrilateral block: input stage, CORDIC
// rotation pipeline, corner sum stage and saturating output register.
// Depends on vsq_pkg and vsq_rotate_stage.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data (req_type)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data (rsp_type)
//
// One transaction enters per cycle while req_stall is low; the pipeline is
// ANGLE_STEPS + 3 registers deep, one CORDIC micro-rotation per rotation stage.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled; empty stages
// keep filling, so a stall at rsp reaches req only once the pipeline is full.
`timescale 1ns / 1ps

module velocity_swept_quad_top #(
   parameter int ANGLE_STEPS = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vsq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vsq_pkg::rsp_type rsp_data
);
   import vsq_pkg::*;

   // ---------------- input stage: setup and multiplies ----------------
   logic               a_valid_ff;
   logic               a_take;
   cord_type           a_cord_ff;
   cord_type           a_cord_in;
   side_type           a_side_ff;
   side_type           a_side_in;
   logic [46:0]        a_sqx_ff;
   logic [46:0]        a_sqy_ff;
   logic [47:0]        a_rsq_ff;
   logic signed [47:0] sqx_full;
   logic signed [47:0] sqy_full;
   logic [47:0]        rsq_full;
   logic [53:0]        gain_prod;
   logic signed [XW-1:0] x_raw;
   logic signed [XW-1:0] y_raw;

   always_comb begin
      x_raw = {{(XW-24-GUARD_BITS){req_data.speed_x[23]}}, req_data.speed_x,
               {GUARD_BITS{1'b0}}};
      y_raw = {{(XW-24-GUARD_BITS){req_data.speed_y[23]}}, req_data.speed_y,
               {GUARD_BITS{1'b0}}};
      sqx_full  = 48'(req_data.speed_x) * 48'(req_data.speed_x);
      sqy_full  = 48'(req_data.speed_y) * 48'(req_data.speed_y);
      rsq_full  = 48'(req_data.circle_radius) * 48'(req_data.circle_radius);
      gain_prod = 54'(req_data.circle_radius) * 54'(INV_GAIN_Q30);

      a_side_in.px      = req_data.center_x;
      a_side_in.py      = req_data.center_y;
      a_side_in.vx      = req_data.speed_x;
      a_side_in.vy      = req_data.speed_y;
      a_side_in.r       = req_data.circle_radius;
      a_side_in.flip    = req_data.speed_x[23];
      a_side_in.still   = (req_data.speed_x == '0) && (req_data.speed_y == '0);
      a_side_in.stretch = 1'b0;

      // Turn a left-pointing velocity by 180 degrees
      if (req_data.speed_x[23]) begin
         a_cord_in.x = -x_raw;
         a_cord_in.y = -y_raw;
      end else begin
         a_cord_in.x = x_raw;
         a_cord_in.y = y_raw;
      end
      a_cord_in.u = $signed({{(UW-54){1'b0}}, gain_prod});
      a_cord_in.w = '0;
   end

   wire [ANGLE_STEPS:0] st_valid;
   wire [ANGLE_STEPS:0] st_stall;
   cord_type            st_cord [ANGLE_STEPS+1];
   side_type            st_side [ANGLE_STEPS+1];
   side_type            s0_side;

   assign a_take    = !a_valid_ff || !st_stall[0];
   assign req_stall = !a_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_take) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take && req_valid) begin
         a_cord_ff <= a_cord_in;
         a_side_ff <= a_side_in;
         a_sqx_ff  <= sqx_full[46:0];
         a_sqy_ff  <= sqy_full[46:0];
         a_rsq_ff  <= rsq_full;
      end
   end

   // Exact speed test, strictly below the radius
   always_comb begin
      s0_side         = a_side_ff;
      s0_side.stretch = ({1'b0, a_sqx_ff} + {1'b0, a_sqy_ff}) < a_rsq_ff;
   end

   assign st_valid[0] = a_valid_ff;
   assign st_cord[0]  = a_cord_ff;
   assign st_side[0]  = s0_side;

   // ---------------- CORDIC rotation pipeline ----------------
   for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_rot
      vsq_rotate_stage #(
         .SHIFT (k)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[k]),
         .in_stall  (st_stall[k]),
         .in_cord   (st_cord[k]),
         .in_side   (st_side[k]),
         .out_valid (st_valid[k+1]),
         .out_stall (st_stall[k+1]),
         .out_cord  (st_cord[k+1]),
         .out_side  (st_side[k+1])
      );
   end

   // ---------------- corner sum stage ----------------
   logic                 f_valid_ff;
   logic                 f_take;
   logic                 out_take;
   sum_type              f_sum_ff [NUM_CORNER_COORDS];
   sum_type              f_sum_in [NUM_CORNER_COORDS];
   cord_type             l_cord;
   side_type             l_side;
   logic signed [UW-1:0] uf;
   logic signed [UW-1:0] wf;
   logic signed [UW-1:0] ur;
   logic signed [UW-1:0] wr;
   logic signed [OW-1:0] ux;
   logic signed [OW-1:0] uy;
   logic signed [OW-1:0] ox;
   logic signed [OW-1:0] oy;
   logic signed [OW-1:0] dx;
   logic signed [OW-1:0] dy;
   logic signed [SW-1:0] pxe;
   logic signed [SW-1:0] pye;

   assign l_cord = st_cord[ANGLE_STEPS];
   assign l_side = st_side[ANGLE_STEPS];

   always_comb begin
      // Negate back what the input stage turned by 180 degrees
      uf = l_side.flip ? -l_cord.u : l_cord.u;
      wf = l_side.flip ? -l_cord.w : l_cord.w;
      ur = (uf + (UW'(1) <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
      wr = (wf + (UW'(1) <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
      ux = ur[OW-1:0];
      uy = wr[OW-1:0];

      if (l_side.still) begin
         ox = OW'($signed({1'b0, l_side.r}));
         oy = '0;
         dx = '0;
         dy = '0;
      end else begin
         ox = uy;
         oy = ux;
         if (l_side.stretch) begin
            dx = ux;
            dy = uy;
         end else begin
            dx = OW'(l_side.vx);
            dy = OW'(l_side.vy);
         end
      end

      pxe = SW'(l_side.px);
      pye = SW'(l_side.py);
      f_sum_in[0] = pxe - SW'(ox);
      f_sum_in[1] = pye + SW'(oy);
      f_sum_in[2] = pxe + SW'(ox);
      f_sum_in[3] = pye - SW'(oy);
      f_sum_in[4] = pxe + SW'(dx) + SW'(ox);
      f_sum_in[5] = pye + SW'(dy) - SW'(oy);
      f_sum_in[6] = pxe + SW'(dx) - SW'(ox);
      f_sum_in[7] = pye + SW'(dy) + SW'(oy);
   end

   assign f_take                = !f_valid_ff || out_take;
   assign st_stall[ANGLE_STEPS] = !f_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_take) begin
         f_valid_ff <= st_valid[ANGLE_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (f_take && st_valid[ANGLE_STEPS]) begin
         f_sum_ff <= f_sum_in;
      end
   end

   // ---------------- saturating output register ----------------
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic [32:0] sat_res [NUM_CORNER_COORDS];
   logic        clip_any;

   always_comb begin
      clip_any = 1'b0;
      for (int i = 0; i < NUM_CORNER_COORDS; i++) begin
         sat_res[i] = sat32(f_sum_ff[i]);
         clip_any   = clip_any | sat_res[i][32];
      end
      rsp_data_in.c1_x    = sat_res[0][31:0];
      rsp_data_in.c1_y    = sat_res[1][31:0];
      rsp_data_in.c2_x    = sat_res[2][31:0];
      rsp_data_in.c2_y    = sat_res[3][31:0];
      rsp_data_in.c3_x    = sat_res[4][31:0];
      rsp_data_in.c3_y    = sat_res[5][31:0];
      rsp_data_in.c4_x    = sat_res[6][31:0];
      rsp_data_in.c4_y    = sat_res[7][31:0];
      rsp_data_in.clipped = clip_any;
   end

   assign out_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && f_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
